FILE: sv/bounded_stack_with_bulk_increment_defines.svh
// Assertion macros shared by the verification files of the bounded stack.
// The macros expect signals named clk and arst_n in the scope of use.
`ifndef BOUNDED_STACK_WITH_BULK_INCREMENT_DEFINES_SVH
`define BOUNDED_STACK_WITH_BULK_INCREMENT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSBI_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, checked outside reset.
`define BSBI_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

FILE: sv/bsbi_pkg.sv
// Package of the bounded stack: widths, operation codes and the
// command and status structs between controller and datapath. No dependencies.
package bsbi_pkg;

	localparam int DEPTH  = 1024;
	localparam int DATA_W = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CAP_W  = 11;
	localparam int MODE_W = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH = 2'd0,
		MODE_POP  = 2'd1,
		MODE_INC  = 2'd2,
		MODE_NOP  = 2'd3
	} bsbi_mode_t;

	typedef struct packed {
		logic push;
		logic pop_rd;
		logic pop_sum;
		logic pop_wr;
		logic pop_empty;
		logic inc_rd;
		logic inc_wr;
	} bsbi_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic inc_hit;
		logic out_free;
	} bsbi_sts_t;

endpackage

FILE: sv/bsbi_if.sv
// Channel interfaces of the bounded stack: request, response and configuration.
// Depends on bsbi_pkg for the field widths.
interface bsbi_req_if;
	logic                              valid;
	logic                              ready;
	logic [bsbi_pkg::MODE_W-1:0]       mode;
	logic signed [bsbi_pkg::DATA_W-1:0] push_value;
	logic [bsbi_pkg::CAP_W-1:0]        inc_count;
	logic signed [bsbi_pkg::DATA_W-1:0] inc_amount;

	modport source (output valid, mode, push_value, inc_count, inc_amount, input ready);
	modport sink (input valid, mode, push_value, inc_count, inc_amount, output ready);
endinterface

interface bsbi_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [bsbi_pkg::DATA_W-1:0] pop_value;
	logic                              was_empty;

	modport source (output valid, pop_value, was_empty, input ready);
	modport sink (input valid, pop_value, was_empty, output ready);
endinterface

interface bsbi_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [bsbi_pkg::CAP_W-1:0] capacity_limit;

	modport source (output valid, capacity_limit, input ready);
	modport sink (input valid, capacity_limit, output ready);
endinterface

FILE: sv/bsbi_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module bsbi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/bsbi_ctrl.sv
// Controller of the bounded stack: sequences push, pop and increment.
// Depends on bsbi_pkg for the operation codes and command/status structs.
module bsbi_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [bsbi_pkg::MODE_W-1:0] req_mode,
	input  bsbi_pkg::bsbi_sts_t         sts,
	output bsbi_pkg::bsbi_cmd_t         cmd
);
	import bsbi_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP_SUM,
		S_POP_WR,
		S_POP_EMPTY,
		S_INC_WR
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_mode)
						MODE_PUSH: begin
							cmd.push = !sts.full;
						end
						MODE_POP: begin
							if (sts.empty) begin
								state_d = S_POP_EMPTY;
							end else begin
								cmd.pop_rd = 1'b1;
								state_d    = S_POP_SUM;
							end
						end
						MODE_INC: begin
							if (sts.inc_hit) begin
								cmd.inc_rd = 1'b1;
								state_d    = S_INC_WR;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_POP_SUM: begin
				cmd.pop_sum = 1'b1;
				state_d     = S_POP_WR;
			end
			S_POP_WR: begin
				if (sts.out_free) begin
					cmd.pop_wr = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_POP_EMPTY: begin
				if (sts.out_free) begin
					cmd.pop_empty = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_INC_WR: begin
				cmd.inc_wr = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: sv/bsbi_dp.sv
// Datapath of the bounded stack: entry count, capacity register, value and
// pending-add RAMs, adders and the result register. Depends on bsbi_pkg, bsbi_ram.
module bsbi_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bsbi_pkg::bsbi_cmd_t                cmd,
	output bsbi_pkg::bsbi_sts_t                sts,
	input  logic signed [bsbi_pkg::DATA_W-1:0] push_value,
	input  logic [bsbi_pkg::CAP_W-1:0]         inc_count,
	input  logic signed [bsbi_pkg::DATA_W-1:0] inc_amount,
	input  logic                               cfg_we,
	input  logic [bsbi_pkg::CAP_W-1:0]         cfg_capacity,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic signed [bsbi_pkg::DATA_W-1:0] pop_value,
	output logic                               was_empty
);
	import bsbi_pkg::*;

	logic [CNT_W-1:0]  count_q;
	logic [CAP_W-1:0]  cap_q;
	logic [ADDR_W-1:0] idx_q;
	logic [DATA_W-1:0] amt_q;
	logic [DATA_W-1:0] add_q;
	logic [DATA_W-1:0] sum_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] pop_value_q;
	logic              was_empty_q;

	logic [CNT_W-1:0]  k_clamp;
	logic [ADDR_W-1:0] top_idx;
	logic [ADDR_W-1:0] k_idx;
	logic              val_we;
	logic [DATA_W-1:0] val_rdata;
	logic              pend_we;
	logic [ADDR_W-1:0] pend_waddr;
	logic [DATA_W-1:0] pend_wdata;
	logic [ADDR_W-1:0] pend_raddr;
	logic [DATA_W-1:0] pend_rdata;

	assign k_clamp = (CNT_W'(inc_count) > count_q) ? count_q : CNT_W'(inc_count);
	assign top_idx = ADDR_W'(count_q - CNT_W'(1));
	assign k_idx   = ADDR_W'(k_clamp - CNT_W'(1));

	assign sts.empty    = (count_q == '0);
	assign sts.full     = (CAP_W'(count_q) >= cap_q) || (count_q >= CNT_W'(DEPTH));
	assign sts.inc_hit  = (k_clamp != '0);
	assign sts.out_free = !out_valid_q || out_ready;

	assign val_we = cmd.push;

	always_comb begin
		pend_we    = 1'b0;
		pend_waddr = idx_q;
		pend_wdata = pend_rdata + amt_q;
		if (cmd.push) begin
			pend_we    = 1'b1;
			pend_waddr = ADDR_W'(count_q);
			pend_wdata = '0;
		end else if (cmd.pop_wr) begin
			pend_we    = (count_q != CNT_W'(1));
			pend_wdata = pend_rdata + add_q;
		end else if (cmd.inc_wr) begin
			pend_we = 1'b1;
		end
		if (cmd.pop_rd) begin
			pend_raddr = top_idx;
		end else if (cmd.inc_rd) begin
			pend_raddr = k_idx;
		end else begin
			pend_raddr = idx_q;
		end
	end

	bsbi_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_val_ram (
		.clk  (clk),
		.we   (val_we),
		.waddr(ADDR_W'(count_q)),
		.wdata(push_value),
		.raddr(top_idx),
		.rdata(val_rdata)
	);

	bsbi_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_pend_ram (
		.clk  (clk),
		.we   (pend_we),
		.waddr(pend_waddr),
		.wdata(pend_wdata),
		.raddr(pend_raddr),
		.rdata(pend_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_capacity;
			end
			if (cmd.push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.pop_wr || cmd.pop_empty) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop_rd) begin
			idx_q <= top_idx - ADDR_W'(1);
		end else if (cmd.inc_rd) begin
			idx_q <= k_idx;
			amt_q <= inc_amount;
		end
		if (cmd.pop_sum) begin
			sum_q <= val_rdata + pend_rdata;
			add_q <= pend_rdata;
		end
		if (cmd.pop_wr) begin
			pop_value_q <= sum_q;
			was_empty_q <= 1'b0;
		end else if (cmd.pop_empty) begin
			pop_value_q <= '1;
			was_empty_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign pop_value = pop_value_q;
	assign was_empty = was_empty_q;

endmodule

FILE: sv/bounded_stack_with_bulk_increment.sv
// Top level of the bounded stack with bulk increment: controller and datapath.
// Depends on bsbi_pkg, bsbi_if, bsbi_ctrl and bsbi_dp.
//
//   channel  direction  payload                                   transaction
//   req      in         mode, push_value, inc_count, inc_amount   one operation
//   rsp      out        pop_value, was_empty                      one pop result
//   cfg      in         capacity_limit                            one register write
//
// A push, an unused mode and an increment that reaches no entry end in S_IDLE. Any other
// increment goes to S_INC_WR, a pop of an empty stack to S_POP_EMPTY and any other pop to
// S_POP_SUM and S_POP_WR: a pop reads the single pending-add read port at two addresses.
// A pop whose result finds the result register still full waits until it drains.
// Reset clears the entry count and sets the capacity to 1024; the RAMs are not
// cleared, as no slot's value is used before a push has written it.
// The configuration channel is always ready.
module bounded_stack_with_bulk_increment (
	input logic      clk,
	input logic      arst_n,
	bsbi_req_if.sink req,
	bsbi_rsp_if.source rsp,
	bsbi_cfg_if.sink cfg
);
	import bsbi_pkg::*;

	bsbi_cmd_t cmd;
	bsbi_sts_t sts;

	assign cfg.ready = 1'b1;

	bsbi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.req_mode (req.mode),
		.sts      (sts),
		.cmd      (cmd)
	);

	bsbi_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.push_value  (req.push_value),
		.inc_count   (req.inc_count),
		.inc_amount  (req.inc_amount),
		.cfg_we      (cfg.valid),
		.cfg_capacity(cfg.capacity_limit),
		.out_ready   (rsp.ready),
		.out_valid   (rsp.valid),
		.pop_value   (rsp.pop_value),
		.was_empty   (rsp.was_empty)
	);

endmodule

FILE: sv/bsbi_checker.sv
// Port-level checks of the bounded stack, bound to its top level.
// Depends on bsbi_pkg and the assertion macros header.
`include "bounded_stack_with_bulk_increment_defines.svh"

module bsbi_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_ready,
	input logic [bsbi_pkg::MODE_W-1:0]        req_mode,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic signed [bsbi_pkg::DATA_W-1:0] rsp_pop_value,
	input logic                               rsp_was_empty
);
	import bsbi_pkg::*;

	`BSBI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_pop_value) && $stable(rsp_was_empty))
	`BSBI_ASSERT_NOW(a_empty_value, rsp_valid && rsp_was_empty, rsp_pop_value == '1)
	`BSBI_ASSERT_NEXT(a_push_one_cycle, req_valid && req_ready && (req_mode == MODE_PUSH),
		req_ready)
	`BSBI_ASSERT_NEXT(a_pop_busy, req_valid && req_ready && (req_mode == MODE_POP),
		!req_ready)

endmodule

bind bounded_stack_with_bulk_increment bsbi_checker u_bsbi_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_mode     (req.mode),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_pop_value(rsp.pop_value),
	.rsp_was_empty(rsp.was_empty)
);

FILE: tb/bounded_stack_with_bulk_increment_test.sv
// Self-checking testbench of the bounded stack with bulk increment: a directed
// run, then random push, pop and increment traffic checked against a predictor.
// Depends on bsbi_pkg, the channel interfaces in bsbi_if and the top level.
module bounded_stack_with_bulk_increment_test;
	import bsbi_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 10;

	typedef struct {
		bsbi_mode_t               mode;
		logic signed [DATA_W-1:0] push_value;
		logic [CAP_W-1:0]         inc_count;
		logic signed [DATA_W-1:0] inc_amount;
	} stack_op_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     empty;
	} pop_result_t;

	logic clk;
	logic arst_n;

	bsbi_req_if req_ch();
	bsbi_rsp_if rsp_ch();
	bsbi_cfg_if cfg_ch();

	bounded_stack_with_bulk_increment dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	stack_op_t   pending_ops[$];
	pop_result_t expected_pops[$];

	logic [DATA_W-1:0] stack_words[DEPTH];
	int                stack_depth;
	logic [CAP_W-1:0]  capacity_reg;

	int send_idle_pct;
	int recv_stall_pct;
	int ops_queued;
	int ops_accepted;
	int mismatch_count;
	int idle_cycles;

	int n_pushed;
	int n_dropped;
	int n_pops;
	int n_empty_pops;
	int n_incs;
	int n_nops;
	int n_results;
	int peak_depth;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic void predict_op(input stack_op_t op);
		int limit;
		int k;
		limit = (capacity_reg < DEPTH) ? int'(capacity_reg) : DEPTH;
		case (op.mode)
			MODE_PUSH: begin
				if (stack_depth < limit) begin
					stack_words[ADDR_W'(stack_depth)] = op.push_value;
					stack_depth++;
					n_pushed++;
					if (stack_depth > peak_depth)
						peak_depth = stack_depth;
				end else begin
					n_dropped++;
				end
			end
			MODE_POP: begin
				n_pops++;
				if (stack_depth == 0) begin
					n_empty_pops++;
					expected_pops.push_back('{value: {DATA_W{1'b1}}, empty: 1'b1});
				end else begin
					stack_depth--;
					expected_pops.push_back('{value: stack_words[ADDR_W'(stack_depth)],
						empty: 1'b0});
				end
			end
			MODE_INC: begin
				n_incs++;
				k = (int'(op.inc_count) > stack_depth) ? stack_depth : int'(op.inc_count);
				for (int i = 0; i < k; i++)
					stack_words[ADDR_W'(i)] = stack_words[ADDR_W'(i)] + op.inc_amount;
			end
			default: begin
				n_nops++;
			end
		endcase
	endfunction

	// Driver of the operation channel.
	always @(posedge clk or negedge arst_n) begin : op_driver
		stack_op_t next_op;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				next_op = pending_ops.pop_front();
				req_ch.valid      <= 1'b1;
				req_ch.mode       <= next_op.mode;
				req_ch.push_value <= next_op.push_value;
				req_ch.inc_count  <= next_op.inc_count;
				req_ch.inc_amount <= next_op.inc_amount;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: results are checked before the same edge's operation is predicted.
	always @(posedge clk) begin : op_monitor
		stack_op_t   seen_op;
		pop_result_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_results++;
				if (expected_pops.size() == 0) begin
					report_mismatch($sformatf("unexpected pop result %0d empty=%0b",
						rsp_ch.pop_value, rsp_ch.was_empty));
				end else begin
					want = expected_pops.pop_front();
					if (rsp_ch.pop_value !== want.value)
						report_mismatch($sformatf("pop_value %0d, expected %0d",
							rsp_ch.pop_value, want.value));
					if (rsp_ch.was_empty !== want.empty)
						report_mismatch($sformatf("was_empty %0b, expected %0b",
							rsp_ch.was_empty, want.empty));
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				seen_op.mode       = bsbi_mode_t'(req_ch.mode);
				seen_op.push_value = req_ch.push_value;
				seen_op.inc_count  = req_ch.inc_count;
				seen_op.inc_amount = req_ch.inc_amount;
				predict_op(seen_op);
				ops_accepted++;
			end
			if (cfg_ch.valid && cfg_ch.ready)
				capacity_reg = cfg_ch.capacity_limit;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic queue_op(input bsbi_mode_t mode, input logic [DATA_W-1:0] push_value,
			input logic [CAP_W-1:0] inc_count, input logic [DATA_W-1:0] inc_amount);
		stack_op_t op;
		op.mode       = mode;
		op.push_value = push_value;
		op.inc_count  = inc_count;
		op.inc_amount = inc_amount;
		pending_ops.push_back(op);
		ops_queued++;
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid          <= 1'b1;
		cfg_ch.capacity_limit <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// Waits until every queued operation is accepted and every pop result has
	// come back, then lets a trailing push or increment finish.
	task automatic drain_and_settle();
		while (ops_accepted != ops_queued || expected_pops.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] random_word();
		case ($urandom_range(9))
			0: random_word = {1'b0, {(DATA_W-1){1'b1}}};
			1: random_word = {1'b1, {(DATA_W-1){1'b0}}};
			2: random_word = {DATA_W{1'b1}};
			3: random_word = '0;
			default: random_word = $urandom;
		endcase
	endfunction

	function automatic logic [CAP_W-1:0] random_count();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: random_count = CAP_W'($urandom_range(0, 12));
			5, 6, 7: random_count = CAP_W'($urandom_range(0, 1100));
			8: random_count = $urandom_range(0, 1) ? CAP_W'(2047) : CAP_W'(1024);
			default: random_count = CAP_W'($urandom_range(0, 2047));
		endcase
	endfunction

	task automatic run_phase(input logic [CAP_W-1:0] cap, input int send_pct,
			input int recv_pct, input int n_ops, input int push_pct, input int pop_pct);
		int roll;
		bsbi_mode_t mode;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		write_capacity(cap);
		repeat (n_ops) begin
			roll = $urandom_range(99);
			if (roll < push_pct)
				mode = MODE_PUSH;
			else if (roll < push_pct + pop_pct)
				mode = MODE_POP;
			else if (roll < 97)
				mode = MODE_INC;
			else
				mode = MODE_NOP;
			queue_op(mode, random_word(), random_count(), random_word());
		end
		drain_and_settle();
	endtask

	initial begin
		arst_n                = 1'b0;
		req_ch.valid          = 1'b0;
		req_ch.mode           = MODE_NOP;
		req_ch.push_value     = '0;
		req_ch.inc_count      = '0;
		req_ch.inc_amount     = '0;
		rsp_ch.ready          = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.capacity_limit = '0;
		stack_depth    = 0;
		capacity_reg   = CAP_RESET;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: a capacity of four makes the full stack easy to reach.
		write_capacity(CAP_W'(4));
		queue_op(MODE_POP, '0, '0, '0);
		queue_op(MODE_INC, '0, CAP_W'(5), 32'd9);
		queue_op(MODE_PUSH, 32'h7fff_ffff, '0, '0);
		queue_op(MODE_PUSH, 32'h8000_0000, '0, '0);
		queue_op(MODE_PUSH, 32'd0, '0, '0);
		queue_op(MODE_PUSH, 32'hffff_ffff, '0, '0);
		queue_op(MODE_PUSH, 32'd123, '0, '0);
		queue_op(MODE_INC, '0, CAP_W'(0), 32'd5);
		queue_op(MODE_INC, '0, CAP_W'(2), 32'd1);
		queue_op(MODE_INC, '0, CAP_W'(2047), 32'h8000_0000);
		queue_op(MODE_NOP, 32'hffff_ffff, CAP_W'(2047), 32'hffff_ffff);
		queue_op(MODE_INC, '0, CAP_W'(3), 32'hffff_ffff);
		queue_op(MODE_INC, '0, CAP_W'(1), 32'h7fff_ffff);
		repeat (5) queue_op(MODE_POP, '0, '0, '0);
		queue_op(MODE_PUSH, 32'd5, '0, '0);
		queue_op(MODE_INC, '0, CAP_W'(1024), 32'd3);
		queue_op(MODE_POP, '0, '0, '0);
		drain_and_settle();

		run_phase(CAP_W'(1024), 0, 0, 100, 45, 30);
		run_phase(CAP_W'(1), 55, 0, 100, 40, 35);
		run_phase(CAP_W'(16), 0, 55, 100, 45, 30);
		// Pushes far beyond the storage depth, so the stack runs full.
		run_phase(CAP_W'(2047), 28, 28, 1150, 94, 3);
		// The capacity falls below the count held; pushes drop while pops drain.
		run_phase(CAP_W'(0), 0, 0, 200, 20, 60);
		run_phase(CAP_W'(32), 28, 28, 100, 45, 30);

		$display("Covered %0d pushes (%0d dropped when full), %0d pops (%0d empty),",
			n_pushed, n_dropped, n_pops, n_empty_pops);
		$display("%0d increments and %0d unused-mode items; %0d results, peak depth %0d.",
			n_incs, n_nops, n_results, peak_depth);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
